@@ hdl/ipe_pkg.sv @@
// Package for the input power estimator: state encoding, fixed-point constants,
// register indexes and the request struct of the shared multiplier.
// No dependencies.
package ipe_pkg;

  // Field widths
  localparam int VinW   = 16;
  localparam int IinW   = 16;
  localparam int PwrW   = 20;
  localparam int VsumW  = 20;
  localparam int IsumW  = 19;
  localparam int OfsW   = 12;
  localparam int ThrW   = 16;
  localparam int RefW   = 15;
  localparam int SlopeW = 19;
  localparam int FacW   = 17;

  // Shared multiplier operand and product widths
  localparam int MulAW = 20;
  localparam int MulBW = 19;
  localparam int MulPW = MulAW + MulBW;

  // Configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_LINE_THR = 8'd0,
    CFG_CURRENT_OFS  = 8'd1
  } ipe_cfg_reg_e;

  localparam logic [ThrW-1:0] THR_RESET = 16'd9600;
  localparam logic [OfsW-1:0] OFS_RESET = 12'd205;

  // Correction factors, Q1.16
  localparam logic [FacW-1:0] Q16_0985 = 17'd64553;
  localparam logic [FacW-1:0] Q16_0995 = 17'd65208;
  localparam logic [FacW-1:0] Q16_1000 = 17'd65536;
  localparam logic [FacW-1:0] Q16_0970 = 17'd63570;
  localparam logic [FacW-1:0] Q16_0980 = 17'd64225;
  localparam logic [FacW-1:0] Q16_0990 = 17'd64881;
  localparam logic [FacW-1:0] Q16_0992 = 17'd65012;

  // Slopes, factor change per 1/16 W step scaled by 2^32
  localparam logic [SlopeW-1:0] SLOPE_1M   = 19'd268435;
  localparam logic [SlopeW-1:0] SLOPE_500U = 19'd134218;
  localparam logic [SlopeW-1:0] SLOPE_10U  = 19'd2684;

  // Power band edges, 1/16 W
  localparam logic [RefW-1:0] P_300W  = 15'd4800;
  localparam logic [RefW-1:0] P_500W  = 15'd8000;
  localparam logic [RefW-1:0] P_1000W = 15'd16000;
  localparam logic [RefW-1:0] P_1500W = 15'd24000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_AVG,
    ST_PWR,
    ST_FAC,
    ST_TRIM,
    ST_SCALE,
    ST_DONE
  } ipe_state_e;

  typedef struct packed {
    logic             en;
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } ipe_mul_req_t;

endpackage

@@ hdl/ipe_if.sv @@
// Handshake interfaces of the input power estimator: sample, result and
// configuration channels. Depends on ipe_pkg.
interface ipe_in_if;
  logic                      valid;
  logic                      ready;
  logic [ipe_pkg::VinW-1:0]  vin_rms;
  logic [ipe_pkg::IinW-1:0]  iin_rms;

  modport source (output valid, vin_rms, iin_rms, input ready);
  modport sink   (input valid, vin_rms, iin_rms, output ready);
endinterface

interface ipe_out_if;
  logic                      valid;
  logic                      ready;
  logic [ipe_pkg::VinW-1:0]  vin_avg;
  logic [ipe_pkg::IinW-1:0]  iin_avg;
  logic [ipe_pkg::PwrW-1:0]  input_power;

  modport source (output valid, vin_avg, iin_avg, input_power, input ready);
  modport sink   (input valid, vin_avg, iin_avg, input_power, output ready);
endinterface

interface ipe_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ipe_pkg::CfgIdxW-1:0]  index;
  logic [ipe_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/input_power_estimator.sv @@
// Input power estimator: smoothed voltage/current and corrected input power.
// Each request steps through accumulate, average, power, factor, trim and scale states.
// Three products share one multiplier. A stalled output holds the done state.
// The block takes no new request until the result is loaded into the output register.
// Reset (async, active low): smoothing sums cleared, threshold 9600, offset 205.
// Depends on ipe_pkg, ipe_if, ipe_mul.
module input_power_estimator (
  input  logic    clk_i,
  input  logic    rst_ni,
  ipe_in_if.sink    in_i,
  ipe_out_if.source out_o,
  ipe_cfg_if.sink   cfg_i
);

  ipe_pkg::ipe_state_e state_q, state_d;

  logic [ipe_pkg::ThrW-1:0]  thr_q;
  logic [ipe_pkg::OfsW-1:0]  ofs_q;
  logic [ipe_pkg::VsumW-1:0] vsum_q;
  logic [ipe_pkg::IsumW-1:0] isum_q;

  logic [ipe_pkg::VinW-1:0]  vin_q, vavg_q, vavg_d;
  logic [ipe_pkg::IinW-1:0]  iin_q, iavg_q, iavg_d;
  logic [ipe_pkg::PwrW-1:0]  p_q;
  logic                      low_q;
  logic [ipe_pkg::FacW-1:0]  c_q, c_d, f_q, f_d;
  logic                      fix_q, fix_d;
  logic [ipe_pkg::RefW-1:0]  ref_d, dlt_d;
  logic [ipe_pkg::SlopeW-1:0] k_d;
  logic [ipe_pkg::IinW:0]    iavg_wide;
  logic [17:0]               trim;
  logic [ipe_pkg::PwrW-1:0]  pw;

  logic                      out_valid_q, out_valid_d, load;
  logic [ipe_pkg::VinW-1:0]  out_vavg_q;
  logic [ipe_pkg::IinW-1:0]  out_iavg_q;
  logic [ipe_pkg::PwrW-1:0]  out_pw_q;

  ipe_pkg::ipe_mul_req_t     mul_req;
  logic [ipe_pkg::MulPW-1:0] prod;

  ipe_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ipe_pkg::ST_IDLE:  if (in_i.valid) state_d = ipe_pkg::ST_ACC;
      ipe_pkg::ST_ACC:   state_d = ipe_pkg::ST_AVG;
      ipe_pkg::ST_AVG:   state_d = ipe_pkg::ST_PWR;
      ipe_pkg::ST_PWR:   state_d = ipe_pkg::ST_FAC;
      ipe_pkg::ST_FAC:   state_d = ipe_pkg::ST_TRIM;
      ipe_pkg::ST_TRIM:  state_d = ipe_pkg::ST_SCALE;
      ipe_pkg::ST_SCALE: state_d = ipe_pkg::ST_DONE;
      ipe_pkg::ST_DONE:  if (!out_valid_q || out_o.ready) state_d = ipe_pkg::ST_IDLE;
      default:           state_d = ipe_pkg::ST_IDLE;
    endcase
  end

  // Averages from the updated sums
  always_comb begin
    vavg_d    = vsum_q[ipe_pkg::VsumW-1:4];
    iavg_wide = {1'b0, isum_q[ipe_pkg::IsumW-1:3]} +
                {{(ipe_pkg::IinW + 1 - ipe_pkg::OfsW){1'b0}}, ofs_q};
    iavg_d    = iavg_wide[ipe_pkg::IinW] ? '1 : iavg_wide[ipe_pkg::IinW-1:0];
  end

  // Band selection from the apparent power
  always_comb begin
    fix_d = 1'b0;
    c_d   = ipe_pkg::Q16_1000;
    ref_d = ipe_pkg::P_300W;
    k_d   = ipe_pkg::SLOPE_1M;
    if (p_q < {5'b0, ipe_pkg::P_300W}) begin
      c_d   = low_q ? ipe_pkg::Q16_0985 : ipe_pkg::Q16_0970;
      ref_d = ipe_pkg::P_300W;
      k_d   = ipe_pkg::SLOPE_1M;
    end else if (p_q < {5'b0, ipe_pkg::P_500W}) begin
      c_d   = low_q ? ipe_pkg::Q16_0995 : ipe_pkg::Q16_0980;
      ref_d = ipe_pkg::P_500W;
      k_d   = ipe_pkg::SLOPE_500U;
    end else if (p_q < {5'b0, ipe_pkg::P_1000W}) begin
      c_d   = low_q ? ipe_pkg::Q16_1000 : ipe_pkg::Q16_0985;
      ref_d = ipe_pkg::P_1000W;
      k_d   = ipe_pkg::SLOPE_10U;
    end else if (!low_q && p_q < {5'b0, ipe_pkg::P_1500W}) begin
      c_d   = ipe_pkg::Q16_0990;
      ref_d = ipe_pkg::P_1500W;
      k_d   = ipe_pkg::SLOPE_10U;
    end else begin
      // flat factor: 1.0 at low line, 0.992 at high line
      fix_d = 1'b1;
      c_d   = low_q ? ipe_pkg::Q16_1000 : ipe_pkg::Q16_0992;
    end
    // p is below ref in every sloped band, so this never wraps there
    dlt_d = ref_d - p_q[ipe_pkg::RefW-1:0];
  end

  always_comb begin
    trim = prod[33:16];
    if (fix_q) begin
      f_d = c_q;
    end else if ({1'b0, c_q} > trim) begin
      f_d = c_q - trim[ipe_pkg::FacW-1:0];
    end else begin
      f_d = '0;
    end
    pw = (|prod[ipe_pkg::MulPW-1:36]) ? '1 : prod[35:16];
  end

  // Outputs of the sequencer
  always_comb begin
    mul_req    = '0;
    in_i.ready = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      ipe_pkg::ST_IDLE: in_i.ready = 1'b1;
      ipe_pkg::ST_AVG: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(ipe_pkg::MulAW - ipe_pkg::VinW){1'b0}}, vavg_d};
        mul_req.b  = {{(ipe_pkg::MulBW - ipe_pkg::IinW){1'b0}}, iavg_d};
      end
      ipe_pkg::ST_FAC: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(ipe_pkg::MulAW - ipe_pkg::RefW){1'b0}}, dlt_d};
        mul_req.b  = k_d;
      end
      ipe_pkg::ST_SCALE: begin
        mul_req.en = 1'b1;
        mul_req.a  = p_q;
        mul_req.b  = {{(ipe_pkg::MulBW - ipe_pkg::FacW){1'b0}}, f_q};
      end
      ipe_pkg::ST_DONE: load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_o.ready;
    end
  end

  assign cfg_i.ready = 1'b1;

  // Control state, configuration registers and smoothing sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipe_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      thr_q       <= ipe_pkg::THR_RESET;
      ofs_q       <= ipe_pkg::OFS_RESET;
      vsum_q      <= '0;
      isum_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          ipe_pkg::CFG_LOW_LINE_THR: thr_q <= cfg_i.data;
          ipe_pkg::CFG_CURRENT_OFS:  ofs_q <= cfg_i.data[ipe_pkg::OfsW-1:0];
          default: ;
        endcase
      end
      if (state_q == ipe_pkg::ST_ACC) begin
        vsum_q <= ipe_pkg::VsumW'(({1'b0, vsum_q} +
                  {{(ipe_pkg::VsumW + 1 - ipe_pkg::VinW){1'b0}}, vin_q}) -
                  {5'b0, vsum_q[ipe_pkg::VsumW-1:4]});
        isum_q <= ipe_pkg::IsumW'(({1'b0, isum_q} +
                  {{(ipe_pkg::IsumW + 1 - ipe_pkg::IinW){1'b0}}, iin_q}) -
                  {4'b0, isum_q[ipe_pkg::IsumW-1:3]});
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      vin_q <= in_i.vin_rms;
      iin_q <= in_i.iin_rms;
    end
    if (state_q == ipe_pkg::ST_AVG) begin
      vavg_q <= vavg_d;
      iavg_q <= iavg_d;
    end
    if (state_q == ipe_pkg::ST_PWR) begin
      p_q   <= prod[31:12];
      low_q <= vavg_q < thr_q;
    end
    if (state_q == ipe_pkg::ST_FAC) begin
      c_q   <= c_d;
      fix_q <= fix_d;
    end
    if (state_q == ipe_pkg::ST_TRIM) begin
      f_q <= f_d;
    end
    if (load) begin
      out_vavg_q <= vavg_q;
      out_iavg_q <= iavg_q;
      out_pw_q   <= pw;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.vin_avg     = out_vavg_q;
  assign out_o.iin_avg     = out_iavg_q;
  assign out_o.input_power = out_pw_q;

endmodule

@@ hdl/ipe_mul.sv @@
// Shared unsigned multiplier with registered product.
// Depends on ipe_pkg.
module ipe_mul (
  input  logic                        clk_i,
  input  ipe_pkg::ipe_mul_req_t       req_i,
  output logic [ipe_pkg::MulPW-1:0]   prod_o
);

  logic [ipe_pkg::MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= {{ipe_pkg::MulBW{1'b0}}, req_i.a} * {{ipe_pkg::MulAW{1'b0}}, req_i.b};
    end
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/ipe_checker.sv @@
// Port-level checks for the input power estimator, bound to the top level.
// Depends on ipe_pkg and input_power_estimator.
module ipe_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ipe_pkg::PwrW-1:0]   out_power
);

  // an accepted request keeps the block busy, with input ready low, after it is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |-> ##1 !in_ready ##1 !in_ready)
    else $error("input ready too soon after request");

  // a new result only comes out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_power))
    else $error("result changed while stalled");

endmodule

bind input_power_estimator ipe_checker u_ipe_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_power (out_o.input_power)
);
